/* hw/rtl/cht_pkg.sv */
package cht_pkg;

   localparam int TABLE_ENTRIES = 8192;
   localparam int IDX_W         = $clog2(TABLE_ENTRIES);
   localparam int KEY_W         = 64;
   localparam int PAY_W         = 16;
   localparam int HASH2_SHIFT   = 16;
   localparam int MAX_KICKS     = 64;
   localparam int KICK_W        = $clog2(MAX_KICKS + 1);

   // request modes, carried in req tuser
   localparam logic MODE_LOOKUP = 1'b0;
   localparam logic MODE_INSERT = 1'b1;

   // req tdata: key then payload, rsp tdata: result word padded to bytes
   localparam int REQ_DATA_W = KEY_W + PAY_W;
   localparam int RSP_BITS   = 1 + PAY_W + IDX_W + 1;
   localparam int RSP_DATA_W = ((RSP_BITS + 7) / 8) * 8;

   typedef struct packed {
      logic [KEY_W-1:0] key;
      logic [PAY_W-1:0] pay;
   } entry_type;

   // packed from the top down, so found lands in bit 0
   typedef struct packed {
      logic             failed;
      logic [IDX_W-1:0] slot;
      logic [PAY_W-1:0] pay;
      logic             found;
   } result_type;

   function automatic logic [IDX_W-1:0] first_hash(input logic [KEY_W-1:0] k);
      first_hash = k[IDX_W-1:0];
   endfunction

   function automatic logic [IDX_W-1:0] second_hash(input logic [KEY_W-1:0] k);
      second_hash = k[HASH2_SHIFT +: IDX_W];
   endfunction

endpackage

/* hw/rtl/cuckoo_hash_table_engine_core.sv */
// channel   dir  handshake              payload
// req       in   req_tvalid/req_tready  tuser: mode, tdata: key, payload
// rsp       out  rsp_tvalid/rsp_tready  tdata: found, payload_out, slot, insert_failed
//
// lookup probes the first slot, and the second slot only on a miss there: one probe per cycle on the
// single read port of the table memory, each probe waits for its registered read
// insert makes at most MAX_KICKS writes; one displacement
// per cycle, the read of the next slot overlapping the write of the current one
// after reset a clearing pass over all TABLE_ENTRIES (8192) slots zeroes the table,
// req_tready stays low meanwhile
// a new beat is taken while a finished result waits in the output register;
// a result that finds that register full parks until rsp_tready frees it
module cuckoo_hash_table_engine_core (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_tvalid,
   output logic                          req_tready,
   input  logic [0:0]                    req_tuser,  // mode
   input  logic [cht_pkg::REQ_DATA_W-1:0] req_tdata, // key, payload
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   output logic [cht_pkg::RSP_DATA_W-1:0] rsp_tdata  // found, payload_out, slot, insert_failed
);
   import cht_pkg::*;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_LOOK1,
      ST_LOOK2,
      ST_INSERT,
      ST_DRAIN
   } state_type;

   // fsm registers
   state_type        state_ff,     state_in;
   logic [IDX_W-1:0] clr_addr_ff,  clr_addr_in;
   logic [KEY_W-1:0] key_ff,       key_in;     // lookup key or carried key
   logic [PAY_W-1:0] pay_ff,       pay_in;     // carried payload
   logic [IDX_W-1:0] idx_ff,       idx_in;     // slot being written
   logic [KICK_W-1:0] kicks_ff,    kicks_in;   // writes made so far
   logic             rsp_valid_ff, rsp_valid_in;
   result_type       rsp_ff,       rsp_in;
   result_type       pend_ff,      pend_in;

   // table memory, one write and one registered read per cycle
   entry_type        mem_ff [TABLE_ENTRIES];
   entry_type        rd_data_ff;
   entry_type        fwd_data_ff;
   logic             fwd_hit_ff;
   logic             mem_we;
   logic [IDX_W-1:0] mem_waddr;
   entry_type        mem_wdata;
   logic [IDX_W-1:0] mem_raddr;
   entry_type        rd_word;

   logic             req_beat;
   logic             out_free;
   logic             done;
   result_type       res;
   logic [IDX_W-1:0] h1_req;
   logic [IDX_W-1:0] h1_old;
   logic [IDX_W-1:0] h2_old;
   logic [KICK_W:0]  kicks_next;
   logic             hit;

   assign req_tready = (state_ff == ST_IDLE);
   assign req_beat   = req_tvalid && req_tready;
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(RSP_DATA_W - RSP_BITS){1'b0}}, rsp_ff};

   // a read at the address written in the same cycle returns the new word
   assign rd_word    = fwd_hit_ff ? fwd_data_ff : rd_data_ff;
   assign h1_req     = first_hash(req_tdata[KEY_W-1:0]);
   assign h1_old     = first_hash(rd_word.key);
   assign h2_old     = second_hash(rd_word.key);
   assign kicks_next = {1'b0, kicks_ff} + (KICK_W + 1)'(1);
   assign hit        = (rd_word.pay != '0) && (rd_word.key == key_ff);

   always_comb begin
      state_in     = state_ff;
      clr_addr_in  = clr_addr_ff;
      key_in       = key_ff;
      pay_in       = pay_ff;
      idx_in       = idx_ff;
      kicks_in     = kicks_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_in       = rsp_ff;
      pend_in      = pend_ff;
      mem_we       = 1'b0;
      mem_waddr    = idx_ff;
      mem_wdata    = '{key: key_ff, pay: pay_ff};
      mem_raddr    = h1_req;
      done         = 1'b0;
      res          = '0;

      unique case (state_ff)
         ST_CLEAR: begin
            mem_we      = 1'b1;
            mem_waddr   = clr_addr_ff;
            mem_wdata   = '0;
            clr_addr_in = clr_addr_ff + IDX_W'(1);
            if (clr_addr_ff == IDX_W'(TABLE_ENTRIES - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_beat) begin
               key_in   = req_tdata[KEY_W-1:0];
               pay_in   = req_tdata[KEY_W +: PAY_W];
               idx_in   = h1_req;
               kicks_in = '0;
               state_in = (req_tuser[0] == MODE_INSERT) ? ST_INSERT : ST_LOOK1;
            end
         end
         ST_LOOK1: begin
            if (hit) begin
               done      = 1'b1;
               res.found = 1'b1;
               res.pay   = rd_word.pay;
               res.slot  = first_hash(key_ff);
            end else begin
               mem_raddr = second_hash(key_ff);
               state_in  = ST_LOOK2;
            end
         end
         ST_LOOK2: begin
            done = 1'b1;
            if (hit) begin
               res.found = 1'b1;
               res.pay   = rd_word.pay;
               res.slot  = second_hash(key_ff);
            end
         end
         ST_INSERT: begin
            // place the carried entry, pick up the old occupant
            mem_we = 1'b1;
            if (rd_word.pay == '0) begin
               done     = 1'b1;
               res.slot = idx_ff;
            end else if (kicks_next >= (KICK_W + 1)'(MAX_KICKS)) begin
               // limit reached, the displaced occupant is dropped
               done       = 1'b1;
               res.slot   = idx_ff;
               res.failed = 1'b1;
            end else begin
               key_in    = rd_word.key;
               pay_in    = rd_word.pay;
               kicks_in  = kicks_next[KICK_W-1:0];
               idx_in    = (idx_ff == h1_old) ? h2_old : h1_old;
               mem_raddr = (idx_ff == h1_old) ? h2_old : h1_old;
            end
         end
         ST_DRAIN: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_in       = pend_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      if (done) begin
         if (out_free) begin
            rsp_valid_in = 1'b1;
            rsp_in       = res;
            state_in     = ST_IDLE;
         end else begin
            pend_in  = res;
            state_in = ST_DRAIN;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_addr_ff  <= '0;
         rsp_valid_ff <= 1'b0;
         kicks_ff     <= '0;
      end else begin
         state_ff     <= state_in;
         clr_addr_ff  <= clr_addr_in;
         rsp_valid_ff <= rsp_valid_in;
         kicks_ff     <= kicks_in;
      end
      key_ff  <= key_in;
      pay_ff  <= pay_in;
      idx_ff  <= idx_in;
      rsp_ff  <= rsp_in;
      pend_ff <= pend_in;
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem_ff[mem_waddr] <= mem_wdata;
      end
      rd_data_ff  <= mem_ff[mem_raddr];
      fwd_hit_ff  <= mem_we && (mem_waddr == mem_raddr);
      fwd_data_ff <= mem_wdata;
   end

   // no table write while waiting for a request
   a_idle_no_write: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE) |-> !mem_we)
      else $error("table written while idle");

   // an accepted beat always starts a probe or an insert
   a_beat_leaves_idle: assert property (@(posedge clock) disable iff (reset)
      req_beat |=> (state_ff == ST_LOOK1 || state_ff == ST_INSERT))
      else $error("accepted beat did not start work");

   // the displacement count stays under the limit
   a_kick_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_INSERT) |-> ({1'b0, kicks_ff} < (KICK_W + 1)'(MAX_KICKS)))
      else $error("displacement count past limit");

   // a parked result only exists behind a full output register
   a_drain_full: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DRAIN) |-> rsp_valid_ff)
      else $error("parked result with empty output register");

   // a failed insert never reports a hit
   a_fail_no_hit: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !(rsp_ff.failed && rsp_ff.found))
      else $error("result both found and failed");

endmodule

/* test/cuckoo_hash_table_engine_core_tb.sv */
`timescale 1ns / 1ps

module cuckoo_hash_table_engine_core_tb;
   import cht_pkg::*;

   // run length guard, far above the slowest legal run (clear pass plus
   // every insert walking the full kick limit under heavy stalls)
   localparam int CYCLE_LIMIT = 300000;
   // quiet cycles after the last result, above the longest insert walk
   localparam int TAIL_CYCLES = 2 * (cht_pkg::MAX_KICKS + 8);
   localparam int HOLD_CYCLES = 300;
   localparam int PHASE_ITEMS = 150;

   typedef struct {
      logic                        mode;
      logic [cht_pkg::KEY_W-1:0]   key;
      logic [cht_pkg::PAY_W-1:0]   pay;
   } request_beat_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                            req_tvalid = 1'b0;
   logic                            req_tready;
   logic [0:0]                      req_tuser  = '0;  // mode
   logic [cht_pkg::REQ_DATA_W-1:0]  req_tdata  = '0;  // key, payload
   logic                            rsp_tvalid;
   logic                            rsp_tready = 1'b0;
   // found, payload_out, slot, insert_failed
   logic [cht_pkg::RSP_DATA_W-1:0]  rsp_tdata;

   cuckoo_hash_table_engine_core dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   // shadow copy of the table, updated in acceptance order
   logic [cht_pkg::KEY_W-1:0] shadow_key [0:cht_pkg::TABLE_ENTRIES-1];
   logic [cht_pkg::PAY_W-1:0] shadow_pay [0:cht_pkg::TABLE_ENTRIES-1];

   request_beat_type           pending_beats [$];
   cht_pkg::result_type        expected_results [$];
   logic [cht_pkg::KEY_W-1:0]  known_keys [$];

   request_beat_type next_beat;
   bit            req_fire      = 1'b0;
   int            send_idle_pct = 0;
   int            stall_pct     = 0;
   bit            hold_start    = 1'b0;
   int            hold_left     = 0;
   int            mismatch_count = 0;
   int            cycle_count   = 0;

   // slots that crowded keys hash to, so chains and full buckets build up
   logic [cht_pkg::IDX_W-1:0] hot_slots [12] = '{
      13'h0000, 13'h1FFF, 13'h0001, 13'h1000, 13'h0ABC, 13'h0555,
      13'h1AAA, 13'h0010, 13'h0777, 13'h1234, 13'h0F0F, 13'h1F00
   };

   // 10 ns clock
   always begin
      clock = 1'b1;
      #5;
      clock = 1'b0;
      #5;
   end

   // shadow table lookup or insert walk, returns the expected result beat
   function automatic cht_pkg::result_type apply_to_shadow_table(
      input logic                      is_insert,
      input logic [cht_pkg::KEY_W-1:0] key,
      input logic [cht_pkg::PAY_W-1:0] pay
   );
      cht_pkg::result_type        res;
      logic [cht_pkg::IDX_W-1:0]  near_idx;
      logic [cht_pkg::IDX_W-1:0]  far_idx;
      logic [cht_pkg::IDX_W-1:0]  idx;
      logic [cht_pkg::KEY_W-1:0]  moving_key;
      logic [cht_pkg::KEY_W-1:0]  old_key;
      logic [cht_pkg::PAY_W-1:0]  moving_pay;
      logic [cht_pkg::PAY_W-1:0]  old_pay;
      int                         writes;
      bit                         done;
      res        = '0;
      near_idx   = key[cht_pkg::IDX_W-1:0];
      far_idx    = key[cht_pkg::HASH2_SHIFT +: cht_pkg::IDX_W];
      moving_key = key;
      moving_pay = pay;
      if (is_insert == MODE_LOOKUP) begin
         // empty entries (payload zero) never match
         if (shadow_pay[near_idx] != '0 && shadow_key[near_idx] == key) begin
            res.found = 1'b1;
            res.pay   = shadow_pay[near_idx];
            res.slot  = near_idx;
         end else if (shadow_pay[far_idx] != '0 && shadow_key[far_idx] == key) begin
            res.found = 1'b1;
            res.pay   = shadow_pay[far_idx];
            res.slot  = far_idx;
         end
      end else begin
         idx    = near_idx;
         writes = 0;
         done   = 1'b0;
         while (!done) begin
            old_key         = shadow_key[idx];
            old_pay         = shadow_pay[idx];
            shadow_key[idx] = moving_key;
            shadow_pay[idx] = moving_pay;
            res.slot        = idx;
            writes++;
            moving_key = old_key;
            moving_pay = old_pay;
            if (moving_pay == '0) begin
               done = 1'b1;
            end else if (writes >= cht_pkg::MAX_KICKS) begin
               // evicted entry is dropped
               res.failed = 1'b1;
               done       = 1'b1;
            end else begin
               // bounce to the other hash of the evicted key
               idx = (idx == moving_key[cht_pkg::IDX_W-1:0]) ?
                     moving_key[cht_pkg::HASH2_SHIFT +: cht_pkg::IDX_W] :
                     moving_key[cht_pkg::IDX_W-1:0];
            end
         end
      end
      return res;
   endfunction

   function automatic void check_field(input string what,
                                       input longint unsigned want,
                                       input longint unsigned got);
      if (want != got) begin
         $display("%0t ns: %s mismatch, expected 0x%0h actual 0x%0h",
                  $time, what, want, got);
         mismatch_count++;
      end
   endfunction

   function automatic logic [cht_pkg::KEY_W-1:0] make_key(input bit crowded);
      logic [cht_pkg::KEY_W-1:0] k;
      k = {$urandom, $urandom};
      if (crowded) begin
         k[cht_pkg::IDX_W-1:0] = hot_slots[$urandom_range(11)];
         // half the crowded keys also have a crowded second hash
         if ($urandom_range(1) == 1)
            k[cht_pkg::HASH2_SHIFT +: cht_pkg::IDX_W] = hot_slots[$urandom_range(11)];
      end
      return k;
   endfunction

   function automatic logic [cht_pkg::PAY_W-1:0] make_payload();
      if ($urandom_range(15) == 0)
         return '0;
      return cht_pkg::PAY_W'($urandom_range(65535, 1));
   endfunction

   task automatic queue_beat(input logic mode,
                             input logic [cht_pkg::KEY_W-1:0] key,
                             input logic [cht_pkg::PAY_W-1:0] pay);
      request_beat_type b;
      b.mode = mode;
      b.key  = key;
      b.pay  = pay;
      pending_beats.push_back(b);
      if (mode == MODE_INSERT) begin
         known_keys.push_back(key);
         if (known_keys.size() > 128)
            void'(known_keys.pop_front());
      end
   endtask

   task automatic queue_random_beats(input int count);
      int                        pick;
      logic [cht_pkg::KEY_W-1:0] key;
      for (int i = 0; i < count; i++) begin
         pick = $urandom_range(99);
         if (pick < 50) begin
            // inserts: mostly crowded keys, some spread, some re-inserts
            if (pick < 32)
               key = make_key(1'b1);
            else if (pick < 42 || known_keys.size() == 0)
               key = make_key(1'b0);
            else
               key = known_keys[$urandom_range(known_keys.size() - 1)];
            queue_beat(MODE_INSERT, key, make_payload());
         end else begin
            // lookups: mostly keys put in earlier, rest noise
            if (pick < 85 && known_keys.size() != 0)
               key = known_keys[$urandom_range(known_keys.size() - 1)];
            else
               key = make_key(pick < 93);
            queue_beat(MODE_LOOKUP, key, make_payload());
         end
      end
   endtask

   // sender idles until every queued beat is taken and every result is back
   task automatic wait_until_drained();
      do
         @(negedge clock);
      while (pending_beats.size() != 0 || req_tvalid || expected_results.size() != 0);
   endtask

   // request driver: inputs change on the falling edge
   always @(negedge clock) begin
      if (!reset && (!req_tvalid || req_fire)) begin
         if (pending_beats.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
            next_beat = pending_beats.pop_front();
            req_tvalid <= 1'b1;
            req_tuser  <= next_beat.mode;
            req_tdata  <= {next_beat.pay, next_beat.key};
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // long receiver hold-off, counted here
   always @(negedge clock) begin
      if (hold_start)
         hold_left <= HOLD_CYCLES;
      else if (hold_left != 0)
         hold_left <= hold_left - 1;
   end

   // result ready with random stalls
   always @(negedge clock) begin
      rsp_tready <= (hold_left == 0) && ($urandom_range(99) >= stall_pct);
   end

   // monitor: both channels sampled on the rising edge
   always @(posedge clock) begin
      cht_pkg::result_type seen;
      cht_pkg::result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         seen = cht_pkg::result_type'(rsp_tdata[cht_pkg::RSP_BITS-1:0]);
         if (expected_results.size() == 0) begin
            $display("%0t ns: unexpected result beat, expected none actual 0x%0h",
                     $time, rsp_tdata);
            mismatch_count++;
         end else begin
            want = expected_results.pop_front();
            check_field("found", want.found, seen.found);
            check_field("payload_out", want.pay, seen.pay);
            check_field("slot", want.slot, seen.slot);
            check_field("insert_failed", want.failed, seen.failed);
         end
      end
      // predict at acceptance, the table changes in this order
      if (!reset && req_tvalid && req_tready)
         expected_results.push_back(apply_to_shadow_table(
            req_tuser[0], req_tdata[cht_pkg::KEY_W-1:0],
            req_tdata[cht_pkg::KEY_W +: cht_pkg::PAY_W]));
      req_fire <= !reset && req_tvalid && req_tready;
   end

   // run guard
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("%0t ns: timeout, %0d results outstanding", $time,
                  expected_results.size());
         $display("DONE: errors detected");
         $finish;
      end
   end

   initial begin
      for (int i = 0; i < cht_pkg::TABLE_ENTRIES; i++) begin
         shadow_key[i] = '0;
         shadow_pay[i] = '0;
      end
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: fresh table misses, extremes, collisions
      queue_beat(MODE_LOOKUP, 64'h0, 16'h0);                      // key zero, empty table
      queue_beat(MODE_LOOKUP, 64'hFFFF_FFFF_FFFF_FFFF, 16'hFFFF);
      queue_beat(MODE_INSERT, 64'h0123_4567_0005_0010, 16'hFFFF);
      queue_beat(MODE_LOOKUP, 64'h0123_4567_0005_0010, 16'h0);    // first slot hit
      // same first hash, pushes the earlier key to its second slot
      queue_beat(MODE_INSERT, 64'hFEDC_BA98_0007_0010, 16'h0001);
      queue_beat(MODE_LOOKUP, 64'h0123_4567_0005_0010, 16'h0);    // second slot hit
      queue_beat(MODE_LOOKUP, 64'hFEDC_BA98_0007_0010, 16'h0);
      // zero payload insert into an empty slot leaves it empty
      queue_beat(MODE_INSERT, 64'h0, 16'h0);
      queue_beat(MODE_LOOKUP, 64'h0, 16'h0);
      // zero payload insert that still displaces an occupant
      queue_beat(MODE_INSERT, 64'h1111_2222_0033_0010, 16'h0);
      queue_beat(MODE_LOOKUP, 64'hFEDC_BA98_0007_0010, 16'h0);
      queue_beat(MODE_LOOKUP, 64'h1111_2222_0033_0010, 16'h0);
      // both hashes equal: second insert walks to the kick limit
      queue_beat(MODE_INSERT, 64'hAAAA_AAAA_0ABC_0ABC, 16'h1234);
      queue_beat(MODE_INSERT, 64'h5555_5555_0ABC_0ABC, 16'h4321);
      queue_beat(MODE_LOOKUP, 64'hAAAA_AAAA_0ABC_0ABC, 16'h0);
      queue_beat(MODE_LOOKUP, 64'h5555_5555_0ABC_0ABC, 16'h0);
      queue_beat(MODE_INSERT, 64'hFFFF_FFFF_FFFF_FFFF, 16'hFFFF);
      queue_beat(MODE_LOOKUP, 64'hFFFF_FFFF_FFFF_FFFF, 16'h0);
      queue_beat(MODE_INSERT, 64'h8000_0000_0000_0000, 16'h8000);
      queue_beat(MODE_LOOKUP, 64'h8000_0000_0000_0000, 16'h0);
      queue_beat(MODE_INSERT, 64'h0, 16'hFFFF);
      queue_beat(MODE_LOOKUP, 64'h0, 16'h0);                      // key zero now present
      wait_until_drained();

      // no idling, with a long receiver hold-off while the sender keeps going
      queue_random_beats(PHASE_ITEMS);
      @(posedge clock);
      hold_start = 1'b1;
      @(posedge clock);
      hold_start = 1'b0;
      wait_until_drained();

      send_idle_pct = 57;
      stall_pct     = 0;
      queue_random_beats(PHASE_ITEMS);
      wait_until_drained();

      send_idle_pct = 0;
      stall_pct     = 57;
      queue_random_beats(PHASE_ITEMS);
      wait_until_drained();

      send_idle_pct = 29;
      stall_pct     = 29;
      queue_random_beats(PHASE_ITEMS);
      wait_until_drained();

      // catch any stray result after the last expected one
      repeat (TAIL_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && expected_results.size() == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

endmodule
